// ----- hdl/crc8pf_pkg.sv -----
package crc8pf_pkg;

   localparam int QueueDepthDefault = 4;

   localparam logic       CMD_START   = 1'b0;
   localparam logic       CMD_PAYLOAD = 1'b1;

   localparam logic [7:0] SYNC_BYTE_0  = 8'h51;
   localparam logic [7:0] SYNC_BYTE_1  = 8'h78;
   localparam logic [7:0] PAD_BYTE     = 8'h00;
   localparam logic [7:0] TRAILER_BYTE = 8'hFF;
   localparam logic [7:0] CRC_POLY     = 8'h07;
   localparam logic [7:0] CRC_INIT     = 8'h00;

   typedef struct packed {
      logic       cmd;
      logic [7:0] packet_code;
      logic [7:0] payload_len;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       packet_end;
      logic       seq_error;
   } rsp_item_type;

   typedef enum logic [1:0] {
      JOB_ERROR,
      JOB_HEADER,
      JOB_PAYLOAD
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   byte_a;
      logic [7:0]   byte_b;
      logic [7:0]   crc;
      logic         tail;
   } job_type;

endpackage

// ----- hdl/crc8pf_front.sv -----
module crc8pf_front
   import crc8pf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_item_type req_item,
   output job_type      job
);

   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] crc_ff, crc_in;
   logic       open_ff, open_in;
   logic [7:0] crc_next;
   logic [7:0] left_next;

   function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

   always_comb begin
      crc_next      = crc_fold(crc_ff, req_item.data_byte);
      left_next     = bytes_left_ff - 8'd1;
      bytes_left_in = bytes_left_ff;
      crc_in        = crc_ff;
      open_in       = open_ff;
      job.kind      = JOB_ERROR;
      job.byte_a    = req_item.packet_code;
      job.byte_b    = req_item.payload_len;
      job.crc       = CRC_INIT;
      job.tail      = 1'b0;
      priority if ((req_item.cmd == CMD_START) == open_ff) begin
         job.kind = JOB_ERROR;
      end else if (req_item.cmd == CMD_START) begin
         job.kind      = JOB_HEADER;
         job.tail      = (req_item.payload_len == 8'd0);
         crc_in        = CRC_INIT;
         bytes_left_in = req_item.payload_len;
         open_in       = (req_item.payload_len != 8'd0);
      end else begin
         job.kind      = JOB_PAYLOAD;
         job.byte_a    = req_item.data_byte;
         job.crc       = crc_next;
         job.tail      = (left_next == 8'd0);
         crc_in        = crc_next;
         bytes_left_in = left_next;
         open_in       = (left_next != 8'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         crc_ff        <= CRC_INIT;
         open_ff       <= 1'b0;
      end else if (accept) begin
         bytes_left_ff <= bytes_left_in;
         crc_ff        <= crc_in;
         open_ff       <= open_in;
      end
   end

endmodule

// ----- hdl/crc8pf_queue.sv -----
module crc8pf_queue
   import crc8pf_pkg::*;
#(
   parameter int DEPTH = QueueDepthDefault
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   job_type         entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full       = (count_ff == CntW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- hdl/crc8pf_back.sv -----
module crc8pf_back
   import crc8pf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         job_valid,
   input  job_type      job,
   output logic         job_pop,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_item_type rsp_item
);

   logic [2:0]   step_ff, step_in;
   logic         out_valid_ff;
   rsp_item_type out_item_ff, out_item_in;
   logic [2:0]   last_step;
   logic         is_last;
   logic         advance;

   assign advance   = job_valid && (!out_valid_ff || rsp_pop);
   assign is_last   = (step_ff == last_step);
   assign job_pop   = advance && is_last;
   assign step_in   = is_last ? 3'd0 : step_ff + 3'd1;
   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_item_ff;

   always_comb begin
      unique case (job.kind)
         JOB_HEADER:  last_step = job.tail ? 3'd7 : 3'd5;
         JOB_PAYLOAD: last_step = job.tail ? 3'd2 : 3'd0;
         default:     last_step = 3'd0;
      endcase
   end

   always_comb begin
      out_item_in.run_last   = is_last;
      out_item_in.packet_end = 1'b0;
      out_item_in.seq_error  = 1'b0;
      out_item_in.out_byte   = PAD_BYTE;
      unique case (job.kind)
         JOB_HEADER: begin
            unique case (step_ff)
               3'd0:    out_item_in.out_byte = SYNC_BYTE_0;
               3'd1:    out_item_in.out_byte = SYNC_BYTE_1;
               3'd2:    out_item_in.out_byte = job.byte_a;
               3'd3:    out_item_in.out_byte = PAD_BYTE;
               3'd4:    out_item_in.out_byte = job.byte_b;
               3'd5:    out_item_in.out_byte = PAD_BYTE;
               3'd6:    out_item_in.out_byte = job.crc;
               default: begin
                  out_item_in.out_byte   = TRAILER_BYTE;
                  out_item_in.packet_end = 1'b1;
               end
            endcase
         end
         JOB_PAYLOAD: begin
            priority if (step_ff == 3'd0) begin
               out_item_in.out_byte = job.byte_a;
            end else if (step_ff == 3'd1) begin
               out_item_in.out_byte = job.crc;
            end else begin
               out_item_in.out_byte   = TRAILER_BYTE;
               out_item_in.packet_end = 1'b1;
            end
         end
         default: begin
            out_item_in.seq_error = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            step_ff      <= step_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

`ifndef SYNTHESIS
   a_step_needs_job: assert property (@(posedge clock) disable iff (reset)
      (step_ff != 3'd0) |-> job_valid)
      else $error("Back end is partway through a job that is no longer queued.");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> (step_ff <= last_step))
      else $error("Back end step counter ran past the end of its job.");

   a_trailer_closes: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.packet_end) |->
         (out_item_ff.out_byte == TRAILER_BYTE) && out_item_ff.run_last)
      else $error("Trailer transfer is malformed or not the final one of its item.");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.seq_error) |->
         (out_item_ff.out_byte == PAD_BYTE) && out_item_ff.run_last
         && !out_item_ff.packet_end)
      else $error("Sequence error transfer carries data or is not final.");
`endif

endmodule

// ----- hdl/crc8_packet_framer_core.sv -----
// Packet framer with CRC-8 (polynomial 0x07, MSB first, initial value zero). A start item
// produces the six header bytes 0x51 0x78 code 0x00 length 0x00, each payload item passes its
// byte through and folds it into the CRC, and after the last payload byte (or right after the
// header for a zero length) the CRC byte and the 0xFF trailer follow. Items out of order give a
// single transfer with seq_error set and change nothing. The front end classifies an item and
// updates the packet state in the cycle it is accepted, so items enter at one per cycle while
// the job queue has room. The back end drives one result transfer per cycle while rsp_pop
// keeps its output register drained; an item yields one result for a payload byte or an
// error, three for the final payload byte, six for a header and eight for a header with
// zero length. That output register sets the sustained rate.
module crc8_packet_framer_core
   import crc8pf_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  req_item_type req_item,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_item_type rsp_item
);

   job_type front_job;
   job_type head_job;
   logic    head_valid;
   logic    head_pop;
   logic    accept;

   assign accept = req_push && !req_full;

   crc8pf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .job      (front_job)
   );

   crc8pf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .push_job   (front_job),
      .full       (req_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   crc8pf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .job_pop   (head_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule
